/* rtl/core/vpru_pkg.sv */
`default_nettype none
package vpru_pkg;

   localparam int COORD_WIDTH_DEF   = 16;
   localparam int CORDIC_STAGES_DEF = 16;
   localparam int ANG_W             = 28;
   localparam int QUEUE_DEPTH       = 4;

   localparam logic [2:0] ACT_TO_POLAR = 3'd0;
   localparam logic [2:0] ACT_TO_RECT  = 3'd1;
   localparam logic [2:0] ACT_ADD      = 3'd2;
   localparam logic [2:0] ACT_NEGATE   = 3'd3;
   localparam logic [2:0] ACT_SCALE    = 3'd4;
   localparam logic [2:0] ACT_PRODUCTS = 3'd5;

   localparam logic signed [ANG_W-1:0] DEG90  = 28'sd5898240;
   localparam logic signed [ANG_W-1:0] DEG180 = 28'sd11796480;
   localparam logic signed [16:0]      DEG180_Q7 = 17'sd23040;
   localparam logic signed [24:0]      GAIN_INV = 25'sd10188014;

   typedef struct packed {
      logic [2:0]         action;
      logic signed [15:0] a_first;
      logic signed [15:0] a_second;
      logic signed [15:0] b_x;
      logic signed [15:0] b_y;
      logic signed [7:0]  scale_factor;
   } req_type;

   typedef struct packed {
      logic signed [15:0] x_out;
      logic signed [15:0] y_out;
      logic [15:0]        modulus_out;
      logic signed [15:0] angle_out;
      logic signed [31:0] dot_out;
      logic signed [31:0] cross_out;
      logic               overflow;
   } rsp_type;

   // one queued job: pre-saturation vector (a itself for both conversions and
   // products), vector b and the raw products
   typedef struct packed {
      logic [2:0]         act;
      logic signed [24:0] vx;
      logic signed [24:0] vy;
      logic signed [15:0] bx;
      logic signed [15:0] by;
      logic signed [33:0] dot;
      logic signed [33:0] crs;
   } job_type;

   function automatic logic signed [ANG_W-1:0] atan_deg(input int i);
      logic signed [ANG_W-1:0] t;
      begin
         unique case (i)
            0: t = 28'sd2949120;   1: t = 28'sd1740967;  2: t = 28'sd919879;
            3: t = 28'sd466945;    4: t = 28'sd234379;   5: t = 28'sd117304;
            6: t = 28'sd58666;     7: t = 28'sd29335;    8: t = 28'sd14668;
            9: t = 28'sd7334;      10: t = 28'sd3667;    11: t = 28'sd1833;
            12: t = 28'sd917;      13: t = 28'sd458;     14: t = 28'sd229;
            15: t = 28'sd115;      16: t = 28'sd57;      17: t = 28'sd29;
            18: t = 28'sd14;       19: t = 28'sd7;       20: t = 28'sd4;
            21: t = 28'sd2;        22: t = 28'sd1;
            default: t = '0;
         endcase
         return t;
      end
   endfunction

   // round half up Q16 degrees to Q9.7, clamp to +-180
   function automatic logic signed [15:0] ang_round(input logic signed [ANG_W-1:0] z);
      logic signed [ANG_W-1:0] r;
      begin
         r = (z + 28'sd256) >>> 9;
         if (r > 28'sd23040) r = 28'sd23040;
         if (r < -28'sd23040) r = -28'sd23040;
         return r[15:0];
      end
   endfunction

endpackage
`default_nettype wire

/* rtl/core/vpru_atan_stage.sv */
`default_nettype none
// One vectoring CORDIC step (angle of a vector), registered.
module vpru_atan_stage #(
   parameter int STAGE = 0,
   parameter int XW    = 40
) (
   input  wire                          clock,
   input  wire                          adv,
   input  wire logic signed [XW-1:0]    px_in,
   input  wire logic signed [XW-1:0]    py_in,
   input  wire logic signed [vpru_pkg::ANG_W-1:0] z_in,
   output logic signed [XW-1:0]         px_ff,
   output logic signed [XW-1:0]         py_ff,
   output logic signed [vpru_pkg::ANG_W-1:0] z_ff
);
   always_ff @(posedge clock) begin
      if (adv) begin
         if (py_in > 0) begin
            px_ff <= px_in + (py_in >>> STAGE);
            py_ff <= py_in - (px_in >>> STAGE);
            z_ff  <= z_in + vpru_pkg::atan_deg(STAGE);
         end else begin
            px_ff <= px_in - (py_in >>> STAGE);
            py_ff <= py_in + (px_in >>> STAGE);
            z_ff  <= z_in - vpru_pkg::atan_deg(STAGE);
         end
      end
   end
endmodule
`default_nettype wire

/* rtl/core/vpru_front.sv */
`default_nettype none
// Front: accept beats, form the pre-saturation vector and products, queue them.
module vpru_front #(
   parameter int DEPTH = vpru_pkg::QUEUE_DEPTH
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_stall,
   input  wire vpru_pkg::req_type req_data,
   output logic               q_valid,
   input  wire                q_take,
   output vpru_pkg::job_type  q_data
);
   localparam int AW = $clog2(DEPTH);
   vpru_pkg::job_type mem_ff [DEPTH];
   logic [AW-1:0] wp_ff, rp_ff;
   logic [AW:0]   cnt_ff;
   vpru_pkg::job_type job;
   logic signed [24:0] vx, vy;
   logic signed [33:0] dot, crs;
   logic signed [15:0] ax, ay, bx, by;
   logic push;

   always_comb begin
      ax = req_data.a_first; ay = req_data.a_second;
      bx = req_data.b_x;     by = req_data.b_y;
      vx = '0; vy = '0;
      unique case (req_data.action)
         vpru_pkg::ACT_TO_POLAR: begin vx = 25'(ax); vy = 25'(ay); end
         vpru_pkg::ACT_TO_RECT:  begin vx = 25'(ax); vy = 25'(ay); end
         vpru_pkg::ACT_ADD:      begin vx = 25'(ax) + 25'(bx); vy = 25'(ay) + 25'(by); end
         vpru_pkg::ACT_NEGATE:   begin vx = -25'(ax); vy = -25'(ay); end
         vpru_pkg::ACT_SCALE: begin
            vx = 25'(ax * req_data.scale_factor);
            vy = 25'(ay * req_data.scale_factor);
         end
         // pass vector a on for the angle of a
         vpru_pkg::ACT_PRODUCTS: begin vx = 25'(ax); vy = 25'(ay); end
         default: ;
      endcase
      dot = 34'(ax * bx) + 34'(ay * by);
      crs = 34'(ax * by) - 34'(ay * bx);
      job.act = req_data.action;
      job.vx  = vx;
      job.vy  = vy;
      job.bx  = bx;
      job.by  = by;
      job.dot = dot;
      job.crs = crs;
   end

   assign req_stall = (cnt_ff == (AW+1)'(DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (cnt_ff != '0);
   assign q_data    = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= job;
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + 1'b1;
         if (q_take) rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (AW+1)'(push) - (AW+1)'(q_take);
      end
   end
endmodule
`default_nettype wire

/* rtl/core/vpru_back.sv */
`default_nettype none
// Back: pipelined rotation CORDIC, saturation, root, vectoring CORDICs.
module vpru_back #(
   parameter int STAGES = vpru_pkg::CORDIC_STAGES_DEF
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          q_valid,
   output logic         q_take,
   input  wire vpru_pkg::job_type q_data,
   output logic         rsp_valid,
   input  wire          rsp_stall,
   output vpru_pkg::rsp_type rsp_data
);
   localparam int AW = vpru_pkg::ANG_W;
   localparam int RW = 46;
   localparam int L  = STAGES + 3 + 17 + STAGES + 1;

   logic [2:0] act_i;
   logic signed [24:0] vx_i, vy_i;
   logic signed [33:0] dot_i, crs_i;
   assign act_i = q_data.act;
   assign vx_i  = q_data.vx;
   assign vy_i  = q_data.vy;
   assign dot_i = q_data.dot;
   assign crs_i = q_data.crs;

   // the whole pipe advances together; a final holding register plus
   // the queue absorb stalls
   logic adv;
   logic [L-1:0] vld_ff;
   assign adv    = !(rsp_valid && rsp_stall);
   assign q_take = adv && q_valid;

   typedef struct packed {
      logic [2:0] act;
      logic signed [15:0] ax, ay, bx, by;
      logic signed [33:0] dot, crs;
   } side_type;

   // ---- rotation CORDIC (polar to rect) ----
   logic signed [RW-1:0] rx [STAGES+1];
   logic signed [RW-1:0] ry [STAGES+1];
   logic signed [AW-1:0] rz [STAGES+1];
   logic signed [24:0]   vx_p [STAGES+1];
   logic signed [24:0]   vy_p [STAGES+1];
   side_type             sd  [STAGES+1];

   always_ff @(posedge clock) begin
      if (adv) begin
         logic signed [AW-1:0] z0;
         logic signed [16:0] m0;
         z0 = AW'($signed(vy_i[15:0])) <<< 9;
         m0 = 17'($signed(vx_i[15:0]));
         if (z0 > vpru_pkg::DEG90) begin z0 = z0 - vpru_pkg::DEG180; m0 = -m0; end
         else if (z0 < -vpru_pkg::DEG90) begin z0 = z0 + vpru_pkg::DEG180; m0 = -m0; end
         rx[0] <= RW'(m0 * vpru_pkg::GAIN_INV);
         ry[0] <= '0;
         rz[0] <= z0;
         vx_p[0] <= vx_i; vy_p[0] <= vy_i;
         sd[0] <= {act_i, vx_i[15:0], vy_i[15:0], q_data.bx, q_data.by,
                   dot_i, crs_i};
      end
   end
   for (genvar s = 0; s < STAGES; s++) begin : g_rot
      always_ff @(posedge clock) begin
         if (adv) begin
            if (rz[s] >= 0) begin
               rx[s+1] <= rx[s] - (ry[s] >>> s);
               ry[s+1] <= ry[s] + (rx[s] >>> s);
               rz[s+1] <= rz[s] - vpru_pkg::atan_deg(s);
            end else begin
               rx[s+1] <= rx[s] + (ry[s] >>> s);
               ry[s+1] <= ry[s] - (rx[s] >>> s);
               rz[s+1] <= rz[s] + vpru_pkg::atan_deg(s);
            end
            vx_p[s+1] <= vx_p[s]; vy_p[s+1] <= vy_p[s]; sd[s+1] <= sd[s];
         end
      end
   end

   // ---- select and saturate ----
   logic signed [RW-1:0] xr, yr;
   logic signed [24:0] sx, sy;
   logic signed [15:0] xs_ff, ys_ff;
   logic ov_ff;
   side_type sd_s_ff;
   always_comb begin
      xr = (rx[STAGES] + RW'(46'sd8388608)) >>> 24;
      yr = (ry[STAGES] + RW'(46'sd8388608)) >>> 24;
      if (sd[STAGES].act == vpru_pkg::ACT_TO_RECT) begin
         sx = 25'(xr); sy = 25'(yr);
      end else begin
         sx = vx_p[STAGES]; sy = vy_p[STAGES];
      end
   end
   function automatic logic signed [15:0] sat16(input logic signed [24:0] v,
                                                output logic o);
      begin
         o = 1'b0;
         if (v > 25'sd32767) begin o = 1'b1; return 16'sh7fff; end
         if (v < -25'sd32768) begin o = 1'b1; return 16'sh8000; end
         return v[15:0];
      end
   endfunction
   always_ff @(posedge clock) begin
      if (adv) begin
         logic o1, o2;
         xs_ff <= sat16(sx, o1);
         ys_ff <= sat16(sy, o2);
         ov_ff <= (o1 || o2) && (sd[STAGES].act <= vpru_pkg::ACT_SCALE);
         sd_s_ff <= sd[STAGES];
      end
   end

   // ---- square root, one bit per stage (16 stages) ----
   logic [31:0] sq_ff;
   logic signed [15:0] xq_ff, yq_ff;
   logic ovq_ff;
   side_type sdq_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         sq_ff <= 32'(xs_ff * xs_ff) + 32'(ys_ff * ys_ff);
         xq_ff <= xs_ff; yq_ff <= ys_ff; ovq_ff <= ov_ff; sdq_ff <= sd_s_ff;
      end
   end
   logic [32:0] rs [17];
   logic [16:0] rr [17];
   logic signed [15:0] xk [17];
   logic signed [15:0] yk [17];
   logic ok [17];
   side_type sk [17];
   assign rs[0] = {1'b0, sq_ff}; assign rr[0] = '0;
   assign xk[0] = xq_ff; assign yk[0] = yq_ff; assign ok[0] = ovq_ff; assign sk[0] = sdq_ff;
   for (genvar k = 0; k < 16; k++) begin : g_sqrt
      logic [32:0] rs_ff; logic [16:0] rr_ff;
      logic signed [15:0] x_ff, y_ff; logic o_ff; side_type s_ff;
      always_ff @(posedge clock) begin
         if (adv) begin
            logic [32:0] trial;
            trial = 33'({rr[k], 2'b01}) << (2*(15-k));
            if (rs[k] >= trial) begin
               rs_ff <= rs[k] - trial; rr_ff <= {rr[k][15:0], 1'b1};
            end else begin
               rs_ff <= rs[k]; rr_ff <= {rr[k][15:0], 1'b0};
            end
            x_ff <= xk[k]; y_ff <= yk[k]; o_ff <= ok[k]; s_ff <= sk[k];
         end
      end
      assign rs[k+1] = rs_ff; assign rr[k+1] = rr_ff;
      assign xk[k+1] = x_ff; assign yk[k+1] = y_ff; assign ok[k+1] = o_ff;
      assign sk[k+1] = s_ff;
   end
   logic [15:0] mod_ff;
   logic signed [15:0] xm_ff, ym_ff;
   logic om_ff; side_type sm_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         mod_ff <= (rs[16] > 33'(rr[16])) ? 16'(rr[16] + 17'd1) : rr[16][15:0];
         xm_ff <= xk[16]; ym_ff <= yk[16]; om_ff <= ok[16]; sm_ff <= sk[16];
      end
   end

   // ---- two vectoring CORDICs: result angle (or angle a), angle b ----
   localparam int VW = 36;
   logic signed [VW-1:0] px [2][STAGES+1];
   logic signed [VW-1:0] py [2][STAGES+1];
   logic signed [AW-1:0] pz [2][STAGES+1];
   logic [1:0] spc [STAGES+1][2];
   logic [15:0] mv [STAGES+1];
   logic signed [15:0] xv [STAGES+1];
   logic signed [15:0] yv [STAGES+1];
   logic ov [STAGES+1];
   side_type sv [STAGES+1];

   function automatic logic [1:0] spec(input logic signed [15:0] x,
                                       input logic signed [15:0] y);
      // 0 none, 1 zero y, 2 zero x
      if (y == 0) return 2'd1;
      if (x == 0) return 2'd2;
      return 2'd0;
   endfunction

   logic signed [15:0] vin_x [2], vin_y [2];
   always_comb begin
      vin_x[0] = (sm_ff.act == vpru_pkg::ACT_PRODUCTS) ? sm_ff.ax : xm_ff;
      vin_y[0] = (sm_ff.act == vpru_pkg::ACT_PRODUCTS) ? sm_ff.ay : ym_ff;
      vin_x[1] = sm_ff.bx; vin_y[1] = sm_ff.by;
   end
   for (genvar c = 0; c < 2; c++) begin : g_vec
      always_ff @(posedge clock) begin
         if (adv) begin
            logic signed [VW-1:0] x0, y0;
            x0 = VW'(vin_x[c]) <<< 16; y0 = VW'(vin_y[c]) <<< 16;
            if (x0 < 0) begin
               if (y0 > 0) begin px[c][0] <= y0; py[c][0] <= -x0; pz[c][0] <= vpru_pkg::DEG90; end
               else begin px[c][0] <= -y0; py[c][0] <= x0; pz[c][0] <= -vpru_pkg::DEG90; end
            end else begin
               px[c][0] <= x0; py[c][0] <= y0; pz[c][0] <= '0;
            end
            spc[0][c] <= spec(vin_x[c], vin_y[c]);
         end
      end
      for (genvar s = 0; s < STAGES; s++) begin : g_st
         vpru_atan_stage #(.STAGE(s), .XW(VW)) u_st (
            .clock(clock), .adv(adv),
            .px_in(px[c][s]), .py_in(py[c][s]), .z_in(pz[c][s]),
            .px_ff(px[c][s+1]), .py_ff(py[c][s+1]), .z_ff(pz[c][s+1]));
         always_ff @(posedge clock) if (adv) spc[s+1][c] <= spc[s][c];
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         mv[0] <= mod_ff; xv[0] <= xm_ff; yv[0] <= ym_ff; ov[0] <= om_ff; sv[0] <= sm_ff;
      end
   end
   for (genvar s = 0; s < STAGES; s++) begin : g_carry
      always_ff @(posedge clock) begin
         if (adv) begin
            mv[s+1] <= mv[s]; xv[s+1] <= xv[s]; yv[s+1] <= yv[s];
            ov[s+1] <= ov[s]; sv[s+1] <= sv[s];
         end
      end
   end

   function automatic logic signed [16:0] ang_fin(input logic [1:0] sp,
                                                  input logic signed [15:0] x,
                                                  input logic signed [15:0] y,
                                                  input logic signed [AW-1:0] z);
      if (sp == 2'd1) return (x < 0) ? vpru_pkg::DEG180_Q7 : 17'sd0;
      if (sp == 2'd2) return (y > 0) ? 17'sd11520 : -17'sd11520;
      return 17'(vpru_pkg::ang_round(z));
   endfunction

   // ---- output register ----
   always_ff @(posedge clock) begin
      if (adv) begin
         logic signed [16:0] a0, a1, d;
         logic signed [33:0] c, dt;
         logic o;
         side_type t;
         vpru_pkg::rsp_type r;
         t  = sv[STAGES];
         a0 = ang_fin(spc[STAGES][0], (t.act == vpru_pkg::ACT_PRODUCTS) ? t.ax : xv[STAGES],
                      (t.act == vpru_pkg::ACT_PRODUCTS) ? t.ay : yv[STAGES], pz[0][STAGES]);
         a1 = ang_fin(spc[STAGES][1], t.bx, t.by, pz[1][STAGES]);
         r = '0;
         if (t.act == vpru_pkg::ACT_PRODUCTS) begin
            o = 1'b0;
            dt = t.dot;
            if (dt > 34'sd2147483647) begin dt = 34'sd2147483647; o = 1'b1; end
            if (dt < -34'sd2147483648) begin dt = -34'sd2147483648; o = 1'b1; end
            c = (t.crs < 0) ? -t.crs : t.crs;
            d = a0 - a1;
            if (d < 0) d = -d;
            if (d > vpru_pkg::DEG180_Q7) c = -c;
            if (c > 34'sd2147483647) begin c = 34'sd2147483647; o = 1'b1; end
            r.dot_out   = dt[31:0];
            r.cross_out = c[31:0];
            r.overflow  = o;
         end else if (t.act <= vpru_pkg::ACT_SCALE) begin
            r.x_out       = xv[STAGES];
            r.y_out       = yv[STAGES];
            r.modulus_out = mv[STAGES];
            r.angle_out   = a0[15:0];
            r.overflow    = ov[STAGES];
         end
         rsp_data <= r;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0; rsp_valid <= 1'b0;
      end else if (adv) begin
         vld_ff    <= {vld_ff[L-2:0], q_valid};
         rsp_valid <= vld_ff[L-1];
      end
   end
endmodule
`default_nettype wire

/* rtl/core/vector_polar_rect_unit_top.sv */
`default_nettype none
// channel | dir | handshake          | beat
// req     | in  | req_valid/req_stall | req_data (action, a, b, scale)
// rsp     | out | rsp_valid/rsp_stall | rsp_data (vector, products, overflow)
// One beat per cycle sustained while rsp_stall is low.
// The pipe runs the rotation CORDIC, saturation, the 16-step root and the vectoring CORDICs.
// Reset clears the queue and the valid pipe only; no state otherwise.
// A held rsp_stall freezes the back pipe once rsp_valid is high; the front queue fills, then req_stall rises.
module vector_polar_rect_unit_top #(
   parameter int CORDIC_STAGES = vpru_pkg::CORDIC_STAGES_DEF
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   input  wire vpru_pkg::req_type req_data,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output vpru_pkg::rsp_type rsp_data
);
   logic q_valid, q_take;
   vpru_pkg::job_type q_data;

   vpru_front u_front (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .req_data(req_data), .q_valid(q_valid), .q_take(q_take), .q_data(q_data));

   vpru_back #(.STAGES(CORDIC_STAGES)) u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_take(q_take),
      .q_data(q_data), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data));
endmodule
`default_nettype wire

/* rtl/core/vpru_checker.sv */
`default_nettype none
module vpru_checker (
   input wire clock,
   input wire reset,
   input wire req_stall,
   input wire rsp_valid,
   input wire rsp_stall,
   input wire vpru_pkg::rsp_type rsp_data
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data)) else $error("rsp held");
   a_rst: assert property (@(posedge clock) reset |=> !rsp_valid) else $error("rst");
   a_rdy: assert property (@(posedge clock) reset |=> !req_stall) else $error("rdy");
   a_ang: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($signed(rsp_data.angle_out) <= 16'sd23040 &&
                     $signed(rsp_data.angle_out) >= -16'sd23040)) else $error("ang");
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.x_out == 0 && rsp_data.y_out == 0 |->
      rsp_data.modulus_out == 0) else $error("mod");
endmodule

bind vector_polar_rect_unit_top vpru_checker u_chk (
   .clock(clock), .reset(reset), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data));
`default_nettype wire

/* verif/tb_top.sv */
module tb_top;
   import vpru_pkg::*;

   localparam int LATENCY   = 2 * CORDIC_STAGES_DEF + 22;
   localparam int N_RANDOM  = 1030;
   localparam int IDLE_LIMIT = 20000;

   localparam logic signed [63:0] COORD_HI = 64'sd32767;
   localparam logic signed [63:0] COORD_LO = -64'sd32768;
   localparam logic signed [63:0] WORD_HI  = 64'sd2147483647;
   localparam logic signed [63:0] WORD_LO  = -64'sd2147483648;
   localparam logic signed [63:0] ONE_DEG  = 64'sd65536;
   localparam logic signed [63:0] HALF_TURN_Q7 = 64'sd23040;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int  errors = 0;
   int  idle_cycles = 0;
   bit  sending_done = 1'b0;
   bit  quiet = 1'b0;
   bit  hold_off = 1'b0;

   vector_polar_rect_unit_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always #6 clock = ~clock;

   task automatic report_mismatch(input string what, input longint got, input longint want);
      errors++;
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
   endtask

   // arithmetic shift right, floor semantics
   function automatic longint shr(input longint v, input int s);
      return v >>> s;
   endfunction

   function automatic logic signed [63:0] arctan_step(input int i);
      logic signed [63:0] t [0:22] = '{2949120, 1740967, 919879, 466945, 234379,
         117304, 58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115,
         57, 29, 14, 7, 4, 2, 1};
      return (i < 23) ? t[i] : 64'sd0;
   endfunction

   function automatic longint clip(input longint v, input longint lo, input longint hi,
                                   inout bit ov);
      if (v > hi) begin ov = 1'b1; return hi; end
      if (v < lo) begin ov = 1'b1; return lo; end
      return v;
   endfunction

   function automatic longint isqrt_round(input longint unsigned s);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > s) b >>= 2;
      while (b != 0) begin
         if (s >= r + b) begin s -= r + b; r = (r >> 1) + b; end
         else r >>= 1;
         b >>= 2;
      end
      return (s > r) ? r + 1 : r;
   endfunction

   function automatic longint direction_q7(input longint x, input longint y);
      longint px, py, z, t, dx, dy, r;
      z = 0;
      if (y == 0) return (x < 0) ? HALF_TURN_Q7 : 0;
      if (x == 0) return (y > 0) ? HALF_TURN_Q7 / 2 : -HALF_TURN_Q7 / 2;
      px = x * ONE_DEG;
      py = y * ONE_DEG;
      if (px < 0) begin
         t = px;
         if (py > 0) begin px = py; py = -t; z = 90 * ONE_DEG; end
         else begin px = -py; py = t; z = -90 * ONE_DEG; end
      end
      for (int i = 0; i < CORDIC_STAGES_DEF; i++) begin
         dx = shr(py, i);
         dy = shr(px, i);
         if (py > 0) begin px += dx; py -= dy; z += arctan_step(i); end
         else begin px -= dx; py += dy; z -= arctan_step(i); end
      end
      r = shr(z + 256, 9);
      if (r > HALF_TURN_Q7) r = HALF_TURN_Q7;
      if (r < -HALF_TURN_Q7) r = -HALF_TURN_Q7;
      return r;
   endfunction

   function automatic void fill_vector(inout rsp_type o, input longint x, input longint y,
                                       inout bit ov);
      longint cx, cy;
      cx = clip(x, COORD_LO, COORD_HI, ov);
      cy = clip(y, COORD_LO, COORD_HI, ov);
      o.x_out = cx[15:0];
      o.y_out = cy[15:0];
      o.modulus_out = 16'(isqrt_round(longint'(cx * cx + cy * cy)));
      o.angle_out = 16'(direction_q7(cx, cy));
   endfunction

   function automatic void rotate_polar(input longint m, input longint th,
                                        output longint xo, output longint yo);
      longint z, px, py, dx, dy;
      z = th * 512;
      py = 0;
      if (z > 90 * ONE_DEG) begin z -= 180 * ONE_DEG; m = -m; end
      else if (z < -90 * ONE_DEG) begin z += 180 * ONE_DEG; m = -m; end
      px = m * 10188014;
      for (int i = 0; i < CORDIC_STAGES_DEF; i++) begin
         dx = shr(py, i);
         dy = shr(px, i);
         if (z >= 0) begin px -= dx; py += dy; z -= arctan_step(i); end
         else begin px += dx; py -= dy; z += arctan_step(i); end
      end
      xo = shr(px + (64'sd1 <<< 23), 24);
      yo = shr(py + (64'sd1 <<< 23), 24);
   endfunction

   function automatic rsp_type vector_result(input req_type q);
      rsp_type o;
      longint ax, ay, bx, by, sf, x, y, dot, c, d;
      bit ov;
      o = '0;
      ov = 1'b0;
      ax = q.a_first; ay = q.a_second; bx = q.b_x; by = q.b_y; sf = q.scale_factor;
      case (q.action)
         ACT_TO_POLAR: fill_vector(o, ax, ay, ov);
         ACT_TO_RECT: begin
            rotate_polar(ax, ay, x, y);
            fill_vector(o, x, y, ov);
         end
         ACT_ADD:    fill_vector(o, ax + bx, ay + by, ov);
         ACT_NEGATE: fill_vector(o, -ax, -ay, ov);
         ACT_SCALE:  fill_vector(o, sf * ax, sf * ay, ov);
         ACT_PRODUCTS: begin
            dot = clip(ax * bx + ay * by, WORD_LO, WORD_HI, ov);
            c = ax * by - ay * bx;
            if (c < 0) c = -c;
            d = direction_q7(ax, ay) - direction_q7(bx, by);
            if (d < 0) d = -d;
            if (d > HALF_TURN_Q7) c = -c;
            c = clip(c, WORD_LO, WORD_HI, ov);
            o.dot_out = dot[31:0];
            o.cross_out = c[31:0];
         end
         default: ;
      endcase
      o.overflow = ov;
      return o;
   endfunction

   class result_board;
      rsp_type pending[$];

      function void note_request(input req_type q);
         pending.push_back(vector_result(q));
      endfunction

      task check_result(input rsp_type r);
         rsp_type e;
         if (pending.size() == 0) begin
            report_mismatch("unexpected beat", 1, 0);
            return;
         end
         e = pending.pop_front();
         if (r.x_out !== e.x_out) report_mismatch("x_out", r.x_out, e.x_out);
         if (r.y_out !== e.y_out) report_mismatch("y_out", r.y_out, e.y_out);
         if (r.modulus_out !== e.modulus_out)
            report_mismatch("modulus_out", r.modulus_out, e.modulus_out);
         if (r.angle_out !== e.angle_out)
            report_mismatch("angle_out", r.angle_out, e.angle_out);
         if (r.dot_out !== e.dot_out) report_mismatch("dot_out", r.dot_out, e.dot_out);
         if (r.cross_out !== e.cross_out)
            report_mismatch("cross_out", r.cross_out, e.cross_out);
         if (r.overflow !== e.overflow)
            report_mismatch("overflow", r.overflow, e.overflow);
      endtask
   endclass

   result_board board = new();
   req_type directed[$];

   function automatic req_type make_req(input logic [2:0] act, input int a1, input int a2,
                                        input int b1, input int b2, input int s);
      req_type q;
      q.action = act;
      q.a_first = 16'(a1);
      q.a_second = 16'(a2);
      q.b_x = 16'(b1);
      q.b_y = 16'(b2);
      q.scale_factor = 8'(s);
      return q;
   endfunction

   function automatic int coord_value();
      case ($urandom_range(0, 9))
         0: return $urandom_range(0, 1) ? 32767 : -32768;
         1: return 0;
         2, 3: return int'($urandom_range(0, 1024)) - 512;
         default: return int'($urandom_range(0, 65535)) - 32768;
      endcase
   endfunction

   function automatic req_type random_req();
      req_type q;
      q.action = ($urandom_range(0, 49) == 0) ? 3'($urandom_range(6, 7))
                                               : 3'($urandom_range(0, 5));
      q.a_first = 16'(coord_value());
      q.a_second = 16'(coord_value());
      q.b_x = 16'(coord_value());
      q.b_y = 16'(coord_value());
      q.scale_factor = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 7) == 0) begin
         if ($urandom_range(0, 1)) q.a_first = 0; else q.a_second = 0;
      end
      return q;
   endfunction

   // offer one beat and hold it until accepted
   task automatic send_beat(input req_type q, input bit may_idle);
      while (may_idle && $urandom_range(0, 99) < 15) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= q;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      directed = '{
         make_req(ACT_TO_POLAR, 0, 0, 0, 0, 0),
         make_req(ACT_TO_POLAR, 256, 0, 0, 0, 0),
         make_req(ACT_TO_POLAR, -256, 0, 0, 0, 0),
         make_req(ACT_TO_POLAR, 0, 256, 0, 0, 0),
         make_req(ACT_TO_POLAR, 0, -256, 0, 0, 0),
         make_req(ACT_TO_POLAR, -32768, -32768, 0, 0, 0),
         make_req(ACT_TO_POLAR, 32767, 32767, 0, 0, 0),
         make_req(ACT_TO_POLAR, -300, -1, 0, 0, 0),
         make_req(ACT_TO_RECT, 256, 5760, 0, 0, 0),
         make_req(ACT_TO_RECT, 32767, -32768, 0, 0, 0),
         make_req(ACT_TO_RECT, -32768, 32767, 0, 0, 0),
         make_req(ACT_TO_RECT, -1000, 23040, 0, 0, 0),
         make_req(ACT_ADD, 32767, -32768, 32767, -32768, 0),
         make_req(ACT_ADD, 100, 200, -100, -200, 0),
         make_req(ACT_NEGATE, -32768, 32767, 0, 0, 0),
         make_req(ACT_NEGATE, 5, -7, 0, 0, 0),
         make_req(ACT_SCALE, 1000, -1000, 0, 0, -128),
         make_req(ACT_SCALE, 3, -4, 0, 0, 127),
         make_req(ACT_PRODUCTS, -32768, -32768, -32768, -32768, 0),
         make_req(ACT_PRODUCTS, 32767, -32768, -32768, 32767, 0),
         make_req(ACT_PRODUCTS, -256, 1, -256, -1, 0),
         make_req(ACT_PRODUCTS, 0, 0, 300, 400, 0),
         make_req(3'd6, 1, 2, 3, 4, 5),
         make_req(3'd7, -1, -1, -1, -1, -1)
      };
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (directed[i]) send_beat(directed[i], 1'b0);
      for (int i = 0; i < N_RANDOM; i++) begin
         quiet = (i >= 300 && i < 450);
         if (i == 600) hold_off = 1'b1;
         send_beat(random_req(), !quiet);
      end
      req_valid <= 1'b0;
      sending_done = 1'b1;
   end

   // receiver stalls; one long hold-off fills the pipe
   initial begin
      @(negedge clock);
      while (1) begin
         if (hold_off) begin
            rsp_stall <= 1'b1;
            repeat (3 * LATENCY) @(negedge clock);
            hold_off = 1'b0;
         end
         rsp_stall <= (!quiet && $urandom_range(0, 99) < 15);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         board.note_request(req_data);
         idle_cycles <= 0;
      end else if (!reset && rsp_valid && !rsp_stall) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (!reset && rsp_valid && !rsp_stall) board.check_result(rsp_data);
   end

   initial begin
      wait (sending_done);
      while (board.pending.size() != 0 && idle_cycles < IDLE_LIMIT) @(posedge clock);
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         repeat (2 * LATENCY) @(posedge clock);
         if (errors == 0) begin
            $display("ALL CHECKS PASSED");
         end else begin
            $display("CHECKS FAILED");
         end
         $finish;
      end
   end

   always @(posedge clock) begin
      if (idle_cycles >= IDLE_LIMIT && !sending_done) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

endmodule

/* files.f */
rtl/core/vpru_pkg.sv
rtl/core/vpru_atan_stage.sv
rtl/core/vpru_front.sv
rtl/core/vpru_back.sv
rtl/core/vector_polar_rect_unit_top.sv
rtl/core/vpru_checker.sv
verif/tb_top.sv
